FILE: rtl/lrs_pkg.sv
// Shared constants for the linear recurrence scan block.
`default_nettype none

package lrs_pkg;

    // Parameter defaults
    localparam int MAX_CHANNELS_DEF = 512;
    localparam int FRAC_BITS_DEF    = 16;

    // Field and register widths
    localparam int VALUE_W       = 32;
    localparam int PROD_W        = 2 * VALUE_W;
    localparam int TIME_W        = 20;
    localparam int NUM_CH_CFG_W  = 10;
    localparam int SEQ_LEN_CFG_W = 21;
    localparam int CFG_DATA_W    = 21;
    localparam int CFG_INDEX_W   = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CHANNELS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEQ_LENGTH   = 1'b1;

    // Register reset values and limits
    localparam logic [NUM_CH_CFG_W-1:0]  NUM_CH_RESET  = 10'd16;
    localparam logic [SEQ_LEN_CFG_W-1:0] SEQ_LEN_RESET = 21'd1024;
    localparam logic [SEQ_LEN_CFG_W-1:0] SEQ_LIMIT     = 21'h10_0000;

endpackage

`default_nettype wire

FILE: rtl/lrs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module lrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/linear_recurrence_scan.sv
// An accepted item is registered in stage 1, in stage 2 and then in the output register.
// Throughput: one item per cycle with two or more channels unless m_tready holds the output;
// with a single channel an item past the first step of a sequence waits while the previous
// item is in stage 1, set by the state loop through the multiplier and round and saturate.
// Reset clears the position counters and pipeline valids and loads the default
// channel count and sequence length; the per-channel state memory is not cleared.
`default_nettype none

module linear_recurrence_scan
    import lrs_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [63:0]            s_tdata,   // [31:0] coef_a, [63:32] term_b
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] state_value
    output logic                        m_tlast,   // step_last
    output logic [1:0]                  m_tuser    // [0] saturated, [1] sequence_last
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
    localparam logic signed [PROD_W-1:0] RND_HALF =
        (FRAC_BITS == 0) ? '0 : (PROD_W'(1) << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] VAL_MAX = {{(PROD_W-VALUE_W+1){1'b0}},
                                                    {(VALUE_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] VAL_MIN = {{(PROD_W-VALUE_W+1){1'b1}},
                                                    {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
        logic            step_last;
        logic            seq_last;
    } item_tag_t;

    // Configuration registers
    logic [NUM_CH_CFG_W-1:0]  num_ch_reg, num_ch_next;
    logic [SEQ_LEN_CFG_W-1:0] seq_len_reg, seq_len_next;

    // Position counters
    logic [CH_W-1:0]   chan_pos_reg, chan_pos_next;
    logic [TIME_W-1:0] time_pos_reg, time_pos_next;

    // Stage 1: memory read returning
    logic                      s1_valid_reg, s1_valid_next;
    logic signed [VALUE_W-1:0] s1_a_reg, s1_b_reg;
    item_tag_t                 s1_tag_reg;
    logic                      s1_fwd_reg;
    logic signed [VALUE_W-1:0] s1_fwd_data_reg;

    // Stage 2: product held, round and saturate
    logic                      s2_valid_reg, s2_valid_next;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    logic signed [VALUE_W-1:0] s2_b_reg;
    item_tag_t                 s2_tag_reg;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_state_reg;
    logic               m_sat_reg, m_step_last_reg, m_seq_last_reg;

    logic [NCH_W-1:0]          nch_eff;
    logic [SEQ_LEN_CFG_W-1:0]  len_eff;
    logic                      step_end, seq_end, first_step;
    logic                      out_free, s2_free, s2_adv, s1_adv, s1_free;
    logic                      hazard, in_accept;
    logic signed [VALUE_W-1:0] ram_rd_data, s1_prev;
    logic signed [PROD_W-1:0]  s1_mult;
    logic signed [PROD_W-1:0]  s2_rounded, s2_sum;
    logic signed [VALUE_W-1:0] s2_x;
    logic                      s2_sat;
    item_tag_t                 in_tag;

    // Clamp the register values to their usable ranges
    always_comb begin
        if (num_ch_reg == '0) begin
            nch_eff = NCH_W'(1);
        end else if (32'(num_ch_reg) > 32'(MAX_CHANNELS)) begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_eff = NCH_W'(num_ch_reg);
        end
        if (seq_len_reg == '0) begin
            len_eff = SEQ_LEN_CFG_W'(1);
        end else if (seq_len_reg > SEQ_LIMIT) begin
            len_eff = SEQ_LIMIT;
        end else begin
            len_eff = seq_len_reg;
        end
    end

    // Mark the end of step and sequence for the item at the input
    assign first_step = (time_pos_reg == '0);
    assign step_end   = ((NCH_W+1)'(chan_pos_reg) + (NCH_W+1)'(1)) >= (NCH_W+1)'(nch_eff);
    assign seq_end    = step_end &&
                        (((TIME_W+1)'(time_pos_reg) + (TIME_W+1)'(1)) >= len_eff);

    assign in_tag.ch        = chan_pos_reg;
    assign in_tag.first     = first_step;
    assign in_tag.step_last = step_end;
    assign in_tag.seq_last  = seq_end;

    // Pipeline flow control
    assign out_free  = !m_valid_reg || m_tready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    // Hold the input while the same channel's previous value is still in stage 1
    assign hazard    = s1_valid_reg && (s1_tag_reg.ch == chan_pos_reg) && !first_step;
    assign s_tready  = s1_free && !hazard;
    assign in_accept = s_tvalid && s_tready;

    // Configuration writes
    always_comb begin
        num_ch_next  = num_ch_reg;
        seq_len_next = seq_len_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_NUM_CHANNELS: num_ch_next  = cfg_wr_data[NUM_CH_CFG_W-1:0];
                CFG_SEQ_LENGTH:   seq_len_next = cfg_wr_data[SEQ_LEN_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Advance the channel and time positions per accepted transaction
    always_comb begin
        chan_pos_next = chan_pos_reg;
        time_pos_next = time_pos_reg;
        if (in_accept) begin
            if (step_end) begin
                chan_pos_next = '0;
                time_pos_next = seq_end ? '0 : time_pos_reg + TIME_W'(1);
            end else begin
                chan_pos_next = chan_pos_reg + CH_W'(1);
            end
        end
    end

    // Stage valids
    assign s1_valid_next = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
    assign m_valid_next  = s2_adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ch_reg   <= NUM_CH_RESET;
            seq_len_reg  <= SEQ_LEN_RESET;
            chan_pos_reg <= '0;
            time_pos_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            num_ch_reg   <= num_ch_next;
            seq_len_reg  <= seq_len_next;
            chan_pos_reg <= chan_pos_next;
            time_pos_reg <= time_pos_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Per-channel state memory: read on accept, write back from stage 2
    lrs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (s2_adv),
        .wr_addr (s2_tag_reg.ch),
        .wr_data (s2_x),
        .rd_en   (in_accept),
        .rd_addr (chan_pos_reg),
        .rd_data (ram_rd_data)
    );

    // Stage 1 load; forward the stage 2 result when it targets the same channel
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_a_reg        <= s_tdata[31:0];
            s1_b_reg        <= s_tdata[63:32];
            s1_tag_reg      <= in_tag;
            s1_fwd_reg      <= s2_valid_reg && (s2_tag_reg.ch == chan_pos_reg);
            s1_fwd_data_reg <= s2_x;
        end
    end

    // Multiply by the previous value
    assign s1_prev = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;
    assign s1_mult = s1_a_reg * s1_prev;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_prod_reg <= s1_mult;
            s2_b_reg    <= s1_b_reg;
            s2_tag_reg  <= s1_tag_reg;
        end
    end

    // Round half-up, add the term and saturate; the first step passes the term
    assign s2_rounded = (s2_prod_reg + RND_HALF) >>> FRAC_BITS;
    assign s2_sum     = s2_rounded + PROD_W'(s2_b_reg);

    always_comb begin
        if (s2_tag_reg.first) begin
            s2_x   = s2_b_reg;
            s2_sat = 1'b0;
        end else if (s2_sum > VAL_MAX) begin
            s2_x   = VAL_MAX[VALUE_W-1:0];
            s2_sat = 1'b1;
        end else if (s2_sum < VAL_MIN) begin
            s2_x   = VAL_MIN[VALUE_W-1:0];
            s2_sat = 1'b1;
        end else begin
            s2_x   = s2_sum[VALUE_W-1:0];
            s2_sat = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_state_reg     <= s2_x;
            m_sat_reg       <= s2_sat;
            m_step_last_reg <= s2_tag_reg.step_last;
            m_seq_last_reg  <= s2_tag_reg.seq_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_state_reg;
    assign m_tlast  = m_step_last_reg;
    assign m_tuser  = {m_seq_last_reg, m_sat_reg};

    // A dependent pair in stages 1 and 2 must have taken the forwarded value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s2_valid_reg && (s1_tag_reg.ch == s2_tag_reg.ch) &&
         !s1_tag_reg.first) |-> s1_fwd_reg)
        else $error("dependent item in stage 1 missed the forwarded value");

    // Closing a step wraps the channel position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && step_end) |=> (chan_pos_reg == '0))
        else $error("channel position did not wrap at the end of a step");

    // The first step of a sequence never saturates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_adv && s2_tag_reg.first) |=> !m_sat_reg)
        else $error("saturation flagged on the first step");

    // A sequence end is always also a step end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_seq_last_reg) |-> m_step_last_reg)
        else $error("sequence end without step end");

endmodule

`default_nettype wire
